// File: design/two_value_key_table_defines.svh
// Assertion macros shared by the two-value key table modules.
`ifndef TWO_VALUE_KEY_TABLE_DEFINES_SVH
`define TWO_VALUE_KEY_TABLE_DEFINES_SVH

`ifndef SYNTH

// invariant checked at every rising clock edge outside reset
`define TVKT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a property in the next
`define TVKT_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define TVKT_ASSERT(label, prop, msg)
`define TVKT_ASSERT_NEXT(label, cond, prop, msg)

`endif

`endif

// File: design/tvkt_pkg.sv
// Types and constants of the two-value key table.
package tvkt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W       = 7;
    localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int MAX_PER_KEY = 2;

    localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_ADD        = 2'd0,
        OP_SEARCH     = 2'd1,
        OP_REMOVE     = 2'd2,
        OP_REMOVE_KEY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_TWO_VALUES = 2'd1,
        ST_FULL       = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } tvkt_item_t;

    typedef struct packed {
        status_t            status;
        logic [1:0]         found_count;
        logic signed [31:0] first_value;
        logic signed [31:0] second_value;
        logic [6:0]         entry_count;
        logic               is_empty;
        logic               is_full;
    } tvkt_result_t;

endpackage

// File: design/tvkt_front.sv
// Input side: accepts words, decodes the command and buffers them in a short queue.
`include "two_value_key_table_defines.svh"

module tvkt_front
    import tvkt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key [31:0], value [63:32]
    input  logic [1:0]  s_axis_tuser,   // command [1:0]
    output logic        item_valid,
    input  logic        item_take,
    output tvkt_item_t  item
);

    tvkt_item_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    tvkt_item_t              new_item;
    logic                    push;
    logic                    pop;

    assign s_axis_tready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign item_valid    = (fill_reg != '0);
    assign pop           = item_take && item_valid;
    assign item          = q_mem[rd_ptr_reg];

    always_comb
    begin
        new_item.op    = op_t'(s_axis_tuser);
        new_item.key   = s_axis_tdata[31:0];
        new_item.value = s_axis_tdata[63:32];
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

    `TVKT_ASSERT(a_fill_bound, fill_reg <= FILL_W'(QUEUE_DEPTH), "queue fill above depth")
    `TVKT_ASSERT_NEXT(a_fill_track, push && !pop, fill_reg == $past(fill_reg) + 1'b1, "fill lost a word")

endmodule

// File: design/tvkt_engine.sv
// Back side: table memory, scan sequencer and output register.
`include "two_value_key_table_defines.svh"

module tvkt_engine
    import tvkt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             item_valid,
    output logic             item_take,
    input  tvkt_item_t       item,
    output logic             out_valid,
    input  logic             out_ready,
    output tvkt_result_t     out_result
);

    logic [63:0]        mem [TABLE_DEPTH];
    logic [63:0]        rd_data_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [63:0]        wr_data;

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [1:0]         found_reg, found_next;
    logic signed [31:0] val0_reg, val0_next;
    logic signed [31:0] val1_reg, val1_next;
    status_t            status_reg, status_next;
    op_t                op_reg, op_next;
    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] value_reg, value_next;
    logic               out_valid_reg, out_valid_next;
    tvkt_result_t       out_reg, out_next;

    logic [CMP_W-1:0]   cap_ext, cap_eff, cnt_cmp;
    logic [CNT_W-1:0]   cnt_minus1, i_inc;
    logic signed [31:0] rd_key, rd_value;
    logic               hit, last, start_full, start_empty, start_done;
    logic               scan_to_move, scan_done, move_done, out_load, keeps_values;

    assign cap_ext     = CMP_W'(cap_reg);
    assign cap_eff     = (cap_ext == '0) ? CMP_W'(1) :
                         (cap_ext > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH) : cap_ext;
    assign cnt_cmp     = CMP_W'(count_reg);
    assign cnt_minus1  = count_reg - 1'b1;
    assign i_inc       = i_reg + 1'b1;
    assign rd_key      = rd_data_reg[31:0];
    assign rd_value    = rd_data_reg[63:32];
    assign last        = (i_inc == count_reg);
    assign hit         = (rd_key == key_reg) && ((op_reg != OP_REMOVE) || (rd_value == value_reg));
    assign keeps_values = (op_reg == OP_SEARCH) || (op_reg == OP_REMOVE_KEY);
    assign start_full  = (item.op == OP_ADD) && (cnt_cmp >= cap_eff);
    assign start_empty = (count_reg == '0);
    assign start_done  = start_full || start_empty;
    assign scan_to_move = hit && ((op_reg == OP_REMOVE) || (op_reg == OP_REMOVE_KEY));
    assign scan_done   = !scan_to_move && (last || (hit && (found_reg == 2'd1) &&
                         ((op_reg == OP_ADD) || (op_reg == OP_SEARCH))));
    assign move_done   = (op_reg == OP_REMOVE) || (found_reg == 2'(MAX_PER_KEY)) ||
                         (i_reg == cnt_minus1);
    assign out_load    = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign out_result  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = start_done ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_to_move)
                begin
                    state_next = S_MOVE;
                end
                else if (scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_MOVE:
            begin
                state_next = move_done ? S_DONE : S_SCAN;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_take   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = i_reg[IDX_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = count_reg[IDX_W-1:0];
        wr_data     = {value_reg, key_reg};
        count_next  = count_reg;
        i_next      = i_reg;
        found_next  = found_reg;
        val0_next   = val0_reg;
        val1_next   = val1_reg;
        status_next = status_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        value_next  = value_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_take   = 1'b1;
                    op_next     = item.op;
                    key_next    = item.key;
                    value_next  = item.value;
                    found_next  = '0;
                    val0_next   = '0;
                    val1_next   = '0;
                    status_next = ST_DONE;
                    i_next      = '0;
                    rd_en       = 1'b1;
                    rd_addr     = '0;
                    if (start_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (start_empty)
                    begin
                        if (item.op == OP_ADD)
                        begin
                            wr_en      = 1'b1;
                            wr_data    = {item.value, item.key};
                            count_next = count_reg + 1'b1;
                        end
                        else if (item.op == OP_REMOVE)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (hit && (op_reg != OP_REMOVE))
                begin
                    found_next = found_reg + 1'b1;
                    if (keeps_values)
                    begin
                        if (found_reg == '0)
                        begin
                            val0_next = rd_value;
                        end
                        else
                        begin
                            val1_next = rd_value;
                        end
                    end
                end
                if (scan_to_move)
                begin
                    rd_en   = 1'b1;
                    rd_addr = cnt_minus1[IDX_W-1:0];
                end
                else if ((op_reg == OP_ADD) && hit && (found_reg == 2'd1))
                begin
                    status_next = ST_TWO_VALUES;
                end
                else if (last)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else if (op_reg == OP_REMOVE)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                else
                begin
                    i_next  = i_inc;
                    rd_en   = 1'b1;
                    rd_addr = i_inc[IDX_W-1:0];
                end
            end
            S_MOVE:
            begin
                // last entry fills the hole; read data is kept as the new slot contents
                wr_en      = 1'b1;
                wr_addr    = i_reg[IDX_W-1:0];
                wr_data    = rd_data_reg;
                count_next = cnt_minus1;
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_load)
        begin
            out_valid_next        = 1'b1;
            out_next.status       = status_reg;
            out_next.found_count  = keeps_values ? found_reg : 2'd0;
            out_next.first_value  = val0_reg;
            out_next.second_value = val1_reg;
            out_next.entry_count  = cnt_cmp[6:0];
            out_next.is_empty     = (count_reg == '0);
            out_next.is_full      = (cnt_cmp >= cap_eff);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        found_reg  <= found_next;
        val0_reg   <= val0_next;
        val1_reg   <= val1_next;
        status_reg <= status_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        value_reg  <= value_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    `TVKT_ASSERT(a_count_bound, count_reg <= CNT_W'(TABLE_DEPTH), "pair count above depth")
    `TVKT_ASSERT(a_move_nonempty, (state_reg != S_MOVE) || (count_reg != '0), "move on empty table")
    `TVKT_ASSERT(a_found_bound, (state_reg == S_IDLE) || (found_reg != 2'd3), "found count above two")
    `TVKT_ASSERT_NEXT(a_load_idle, out_load, (state_reg == S_IDLE) && out_valid_reg, "result not issued")

endmodule

// File: design/two_value_key_table.sv
// Words wait in the input queue until the engine is idle; it takes one command at a time.
// The table scan reads one entry per cycle, paused while a remove moves a pair.
// Remove fills a hole with the last pair; full-table add and empty-table commands skip the scan.
// Reset (rst_n low, async): table empty, queue and output cleared, capacity 64.
// Table memory has no clearing pass; only entries below the pair count are read.
`include "two_value_key_table_defines.svh"

module two_value_key_table
    import tvkt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,   // capacity_limit
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,  // key [31:0], value [63:32]
    input  logic [1:0]       s_axis_tuser,  // command [1:0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [79:0]      m_axis_tdata,  // found_count [1:0], first_value [33:2],
                                            // second_value [65:34], entry_count [72:66],
                                            // is_empty [73], is_full [74], zero [79:75]
    output logic [1:0]       m_axis_tuser   // status [1:0]
);

    tvkt_item_t   item;
    logic         item_valid;
    logic         item_take;
    tvkt_result_t result;

    tvkt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (item_valid),
        .item_take     (item_take),
        .item          (item)
    );

    tvkt_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_take   (item_take),
        .item        (item),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (result)
    );

    assign m_axis_tuser = result.status;
    assign m_axis_tdata = {5'd0, result.is_full, result.is_empty, result.entry_count,
                           result.second_value, result.first_value, result.found_count};

    `TVKT_ASSERT(a_take_needs_word, !item_take || item_valid, "engine took from empty queue")

endmodule

// File: bench/tb_two_value_key_table.sv
`timescale 1ns / 100ps
// Self-checking testbench for two_value_key_table: directed and random streaming traffic against a table predictor.
module tb_two_value_key_table;
    import tvkt_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [63:0]      s_axis_tdata = '0;    // key [31:0], value [63:32]
    logic [1:0]       s_axis_tuser = '0;    // command [1:0]
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [79:0]      m_axis_tdata;         // found_count, first_value, second_value,
                                            // entry_count, is_empty, is_full, zero pad
    logic [1:0]       m_axis_tuser;         // status [1:0]

    two_value_key_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // table shadow
    logic signed [31:0] tbl_key [TABLE_DEPTH];
    logic signed [31:0] tbl_val [TABLE_DEPTH];
    int                 stored = 0;
    logic [CFG_W-1:0]   cap_model = CAP_RESET;

    tvkt_item_t   commands_todo [$];
    tvkt_result_t replies_due [$];
    tvkt_item_t   cur_cmd;
    tvkt_item_t   recent_adds [$];
    logic [31:0]  key_pool [12];
    logic [31:0]  val_pool [4];

    int cmds_queued = 0;
    int cmds_taken = 0;
    int words_seen = 0;
    int mismatches = 0;
    int sent = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int rx_cycles = 0;
    int hold_left = 0;
    bit held_once = 1'b0;
    bit steady_tx = 1'b0;
    bit steady_rx = 1'b0;

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void drop_entry(int i);
        tbl_key[i] = tbl_key[stored-1];
        tbl_val[i] = tbl_val[stored-1];
        stored = stored - 1;
    endfunction

    function automatic tvkt_result_t table_apply(tvkt_item_t c);
        tvkt_result_t r;
        int i;
        int hits;
        int cap;
        r = '0;
        cap = cap_model;
        if (cap < 1)
            cap = 1;
        if (cap > TABLE_DEPTH)
            cap = TABLE_DEPTH;
        case (c.op)
            OP_ADD:
            begin
                if (stored >= cap)
                    r.status = ST_FULL;
                else
                begin
                    hits = 0;
                    for (i = 0; i < stored; i++)
                        if (tbl_key[i] == c.key)
                            hits++;
                    if (hits >= MAX_PER_KEY)
                        r.status = ST_TWO_VALUES;
                    else
                    begin
                        tbl_key[stored] = c.key;
                        tbl_val[stored] = c.value;
                        stored = stored + 1;
                    end
                end
            end
            OP_SEARCH:
            begin
                for (i = 0; i < stored && r.found_count < MAX_PER_KEY; i++)
                begin
                    if (tbl_key[i] == c.key)
                    begin
                        if (r.found_count == 0)
                            r.first_value = tbl_val[i];
                        else
                            r.second_value = tbl_val[i];
                        r.found_count++;
                    end
                end
            end
            OP_REMOVE:
            begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < stored; i++)
                begin
                    if (tbl_key[i] == c.key && tbl_val[i] == c.value)
                    begin
                        drop_entry(i);
                        r.status = ST_DONE;
                        break;
                    end
                end
            end
            default:
            begin
                i = 0;
                while (i < stored && r.found_count < MAX_PER_KEY)
                begin
                    if (tbl_key[i] == c.key)
                    begin
                        if (r.found_count == 0)
                            r.first_value = tbl_val[i];
                        else
                            r.second_value = tbl_val[i];
                        r.found_count++;
                        drop_entry(i);
                    end
                    else
                        i++;
                end
            end
        endcase
        r.entry_count = 7'(stored);
        r.is_empty = (stored == 0);
        r.is_full = (stored >= cap);
        return r;
    endfunction

    task automatic queue_cmd(op_t op, logic [31:0] key, logic [31:0] value);
        tvkt_item_t c;
        c.op = op;
        c.key = key;
        c.value = value;
        commands_todo.push_back(c);
        cmds_queued++;
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cap_model = v;
    endtask

    task automatic wait_drained();
        while (!(cmds_taken == cmds_queued && words_seen == cmds_taken))
            @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);
    endtask

    task automatic gen_random(int n, int add_pct);
        int k;
        int r;
        int p;
        op_t op;
        logic [31:0] key;
        logic [31:0] value;
        tvkt_item_t pick;
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            p = (100 - add_pct) / 3;
            if (r < add_pct)
                op = OP_ADD;
            else if (r < add_pct + p)
                op = OP_SEARCH;
            else if (r < add_pct + 2 * p)
                op = OP_REMOVE;
            else
                op = OP_REMOVE_KEY;
            key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 11)] : $urandom;
            value = ($urandom_range(0, 4) == 0) ? val_pool[$urandom_range(0, 3)] : $urandom;
            if (op == OP_REMOVE && recent_adds.size() > 0 && $urandom_range(0, 9) < 6)
            begin
                pick = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
                key = pick.key;
                value = pick.value;
            end
            if (op == OP_ADD)
            begin
                pick.op = op;
                pick.key = key;
                pick.value = value;
                recent_adds.push_back(pick);
                if (recent_adds.size() > 32)
                    void'(recent_adds.pop_front());
            end
            queue_cmd(op, key, value);
        end
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on word %0d, %s: expected %h, got %h",
                         words_seen, name, want, got);
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                replies_due.push_back(table_apply(cur_cmd));
                cmds_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (commands_todo.size() > 0)
                begin
                    cur_cmd = commands_todo.pop_front();
                    s_axis_tdata <= {cur_cmd.value, cur_cmd.key};
                    s_axis_tuser <= cur_cmd.op;
                    s_axis_tvalid <= 1'b1;
                    sent++;
                    if (sent % 64 == 0)
                        steady_tx = ($urandom_range(0, 3) == 0);
                    tx_gap = steady_tx ? 0 : pick_gap();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            rx_cycles++;
            if (rx_cycles % 128 == 0)
                steady_rx = ($urandom_range(0, 3) == 0);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!held_once && words_seen >= 150)
            begin
                held_once = 1'b1;
                hold_left = 600;
                m_axis_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_gap = steady_rx ? 0 : pick_gap();
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        tvkt_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_seen++;
            if (replies_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %h / %h", m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = replies_due.pop_front();
                compare_field("status", 32'(want.status), 32'(m_axis_tuser));
                compare_field("found_count", 32'(want.found_count), 32'(m_axis_tdata[1:0]));
                compare_field("first_value", want.first_value, m_axis_tdata[33:2]);
                compare_field("second_value", want.second_value, m_axis_tdata[65:34]);
                compare_field("entry_count", 32'(want.entry_count), 32'(m_axis_tdata[72:66]));
                compare_field("is_empty", 32'(want.is_empty), 32'(m_axis_tdata[73]));
                compare_field("is_full", 32'(want.is_full), 32'(m_axis_tdata[74]));
            end
        end
    end

    initial begin
        int k;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        key_pool[4] = 32'h0000_0001;
        key_pool[5] = 32'h5555_5555;
        key_pool[6] = 32'haaaa_aaaa;
        for (k = 7; k < 12; k++)
            key_pool[k] = $urandom;
        val_pool[0] = 32'h0000_0000;
        val_pool[1] = 32'hffff_ffff;
        val_pool[2] = 32'h8000_0000;
        val_pool[3] = 32'h7fff_ffff;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, extremes, two-value limit, swap-in removal
        queue_cmd(OP_SEARCH, 32'h0, 32'hffff_ffff);
        queue_cmd(OP_REMOVE_KEY, 32'h0, 32'h0);
        queue_cmd(OP_REMOVE, 32'h0, 32'h0);
        queue_cmd(OP_ADD, 32'h8000_0000, 32'h7fff_ffff);
        queue_cmd(OP_ADD, 32'h8000_0000, 32'h8000_0000);
        queue_cmd(OP_ADD, 32'h8000_0000, 32'h0);
        queue_cmd(OP_SEARCH, 32'h8000_0000, 32'h0);
        queue_cmd(OP_ADD, 32'h7fff_ffff, 32'hffff_ffff);
        queue_cmd(OP_ADD, 32'hffff_ffff, 32'h7fff_ffff);
        queue_cmd(OP_ADD, 32'h0, 32'h0);
        queue_cmd(OP_REMOVE, 32'h8000_0000, 32'h1);
        queue_cmd(OP_REMOVE, 32'h8000_0000, 32'h8000_0000);
        queue_cmd(OP_SEARCH, 32'h8000_0000, 32'h0);
        queue_cmd(OP_ADD, 32'h8000_0000, 32'h5);
        queue_cmd(OP_REMOVE_KEY, 32'h8000_0000, 32'h0);
        queue_cmd(OP_REMOVE_KEY, 32'h7fff_ffff, 32'h0);
        queue_cmd(OP_SEARCH, 32'hffff_ffff, 32'h0);
        queue_cmd(OP_REMOVE, 32'hffff_ffff, 32'h7fff_ffff);
        queue_cmd(OP_REMOVE_KEY, 32'h0, 32'h0);
        queue_cmd(OP_SEARCH, 32'h1234_5678, 32'h0);
        wait_drained();

        // full with a key already at two values
        write_capacity(7'd3);
        queue_cmd(OP_ADD, 32'h11, 32'h1);
        queue_cmd(OP_ADD, 32'h11, 32'h2);
        queue_cmd(OP_ADD, 32'h22, 32'h3);
        queue_cmd(OP_ADD, 32'h11, 32'h4);
        wait_drained();

        // capacity below the stored count
        write_capacity(7'd1);
        queue_cmd(OP_ADD, 32'h33, 32'h5);
        queue_cmd(OP_SEARCH, 32'h11, 32'h0);
        wait_drained();

        // zero capacity acts as one
        write_capacity(7'd0);
        queue_cmd(OP_REMOVE_KEY, 32'h11, 32'h0);
        queue_cmd(OP_REMOVE_KEY, 32'h22, 32'h0);
        queue_cmd(OP_ADD, 32'h44, 32'h6);
        queue_cmd(OP_ADD, 32'h55, 32'h7);
        wait_drained();

        write_capacity(7'd127);
        gen_random(180, 75);
        wait_drained();
        write_capacity(7'd2);
        gen_random(150, 35);
        wait_drained();
        write_capacity(7'd64);
        gen_random(180, 50);
        wait_drained();
        write_capacity(7'd100);
        gen_random(180, 60);
        wait_drained();
        write_capacity(7'd8);
        gen_random(170, 45);
        wait_drained();
        write_capacity(7'd5);
        gen_random(170, 45);
        wait_drained();
        write_capacity(7'd64);
        gen_random(170, 40);
        wait_drained();

        if (replies_due.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
